FILE: hw/rtl/gha_pkg.sv
// shared types and constants of the generational handle allocator
// no dependencies; every other rtl file imports this package
`default_nettype none

package gha_pkg;

    // fixed widths of the word fields
    localparam int OP_W   = 2;
    localparam int HIDX_W = 11;
    localparam int SIDX_W = 10;
    localparam int HGEN_W = 16;
    localparam int STAT_W = 2;
    localparam int CAP_W  = 11;

    // defaults for the top level parameters
    localparam int DEF_MAX_SLOTS = 1024;
    localparam int DEF_GEN_BITS  = 16;

    // capacity after reset, before min with the slot count
    localparam int CAP_RESET = 1024;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC    = 2'd0,
        OP_RELEASE  = 2'd1,
        OP_VALIDATE = 2'd2,
        OP_TICK     = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_ALLOC_GEN,
        S_TICK
    } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/gha_req_if.sv
// request channel of the handle allocator: valid/ready plus request word
// depends on gha_pkg
`default_nettype none

interface gha_req_if;
    import gha_pkg::*;

    logic                     valid;
    logic                     ready;
    op_t                      op;
    logic signed [HIDX_W-1:0] handle_index;
    logic [HGEN_W-1:0]        handle_generation;

    modport source (output valid, output op, output handle_index,
                    output handle_generation, input ready);
    modport sink   (input valid, input op, input handle_index,
                    input handle_generation, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/gha_rsp_if.sv
// response channel of the handle allocator: valid/ready plus result word
// depends on gha_pkg
`default_nettype none

interface gha_rsp_if;
    import gha_pkg::*;

    logic              valid;
    logic              ready;
    status_t           status;
    logic [SIDX_W-1:0] slot_index;
    logic [HGEN_W-1:0] slot_generation;
    logic              is_live;

    modport source (output valid, output status, output slot_index,
                    output slot_generation, output is_live, input ready);
    modport sink   (input valid, input status, input slot_index,
                    input slot_generation, input is_live, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/generational_handle_allocator.sv
// generational handle allocator top level: free stack, generation table, pending list
// depends on gha_pkg, gha_req_if, gha_rsp_if
`default_nettype none

// Slot allocator handing out (index, generation) handles. Each request word yields
// exactly one response word. Validate and release read the generation table, then
// compare (release also writes back); allocate first reads the free stack memory,
// because the generation read depends on the slot popped from it. Tick walks the
// pending list one entry per cycle through its memory read port, pushing each entry
// onto the free stack while it has room, and answers once the list is walked. After
// reset and after every capacity write the block zeroes the generation table up to
// the capacity, one entry per cycle, during which req.ready stays low. Capacity above
// MAX_SLOTS is clamped to MAX_SLOTS. The response sits in an output register, so a
// new request is taken while the previous response still waits for rsp.ready.
// Capacity may only be written while idle; any write resets generations, the free
// stack and the pending list.
module generational_handle_allocator #(
    parameter int MAX_SLOTS = gha_pkg::DEF_MAX_SLOTS,
    parameter int GEN_BITS  = gha_pkg::DEF_GEN_BITS
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      cfg_we,
    input  wire [gha_pkg::CAP_W-1:0] cfg_wdata,
    gha_req_if.sink                  req,
    gha_rsp_if.source                rsp
);
    import gha_pkg::*;

    localparam int IDX_W = $clog2(MAX_SLOTS);
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_SLOTS);
    localparam logic [CNT_W-1:0] RST_CAP  =
        (CAP_RESET > MAX_SLOTS) ? CNT_W'(MAX_SLOTS) : CNT_W'(CAP_RESET);

    // memories
    logic [IDX_W-1:0]    free_mem [MAX_SLOTS];
    logic [GEN_BITS-1:0] gen_mem  [MAX_SLOTS];
    logic [IDX_W-1:0]    pend_mem [MAX_SLOTS];

    logic                free_we, free_re;
    logic [IDX_W-1:0]    free_waddr, free_raddr, free_wdata, free_rd_q;
    logic                gen_we, gen_re;
    logic [IDX_W-1:0]    gen_waddr, gen_raddr;
    logic [GEN_BITS-1:0] gen_wdata, gen_rd_q;
    logic                pend_we, pend_re;
    logic [IDX_W-1:0]    pend_waddr, pend_raddr, pend_wdata, pend_rd_q;

    // control state
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cap_reg, cap_next;
    logic [CNT_W-1:0]    fc_reg, fc_next;      // free count
    logic [CNT_W-1:0]    lw_reg, lw_next;      // lowest free count since rebuild
    logic [CNT_W-1:0]    pc_reg, pc_next;      // pending count
    logic [CNT_W-1:0]    clr_reg, clr_next;
    logic [CNT_W-1:0]    tick_idx_reg, tick_idx_next;
    logic                tick_vld_reg, tick_vld_next;

    // request capture
    op_t                 op_reg, op_next;
    logic                hok_reg, hok_next;    // handle index in range
    logic [IDX_W-1:0]    addr_reg, addr_next;
    logic [GEN_BITS-1:0] hgen_reg, hgen_next;
    logic [IDX_W-1:0]    sidx_reg, sidx_next;

    // output register
    logic                ov_reg, ov_next;
    status_t             ostat_reg, ostat_next;
    logic [SIDX_W-1:0]   oidx_reg, oidx_next;
    logic [HGEN_W-1:0]   ogen_reg, ogen_next;
    logic                olive_reg, olive_next;

    logic                accept, out_free, tick_done, live;
    logic [CNT_W-1:0]    pos, cfg_cap;
    logic [IDX_W-1:0]    req_addr, pop_idx;
    logic                req_in_range;

    assign accept    = req.valid && req.ready;
    assign out_free  = !ov_reg || rsp.ready;
    assign tick_done = !tick_vld_reg && (tick_idx_reg == pc_reg);
    assign req.ready = (state_reg == S_IDLE);

    assign rsp.valid           = ov_reg;
    assign rsp.status          = ostat_reg;
    assign rsp.slot_index      = oidx_reg;
    assign rsp.slot_generation = ogen_reg;
    assign rsp.is_live         = olive_reg;

    // null handle has the sign bit set; range is checked against the live capacity
    assign req_in_range = !req.handle_index[HIDX_W-1] &&
        (32'(req.handle_index[SIDX_W-1:0]) < 32'(cap_reg));
    assign req_addr = IDX_W'(32'(req.handle_index[SIDX_W-1:0]));

    // top of stack; entries below the watermark were never rewritten and hold their index
    assign pos     = fc_reg - CNT_W'(1);
    assign pop_idx = (pos < lw_reg) ? IDX_W'(pos) : free_rd_q;
    assign live    = hok_reg && (gen_rd_q == hgen_reg);

    assign cfg_cap = (32'(cfg_wdata) > 32'(MAX_SLOTS)) ? FULL_CNT : CNT_W'(cfg_wdata);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == cap_reg)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                    state_next = (req.op == OP_TICK) ? S_TICK : S_LOOKUP;
            end
            S_LOOKUP:
            begin
                if (op_reg == OP_ALLOC && fc_reg != '0)
                    state_next = S_ALLOC_GEN;
                else if (out_free)
                    state_next = S_IDLE;
            end
            S_ALLOC_GEN:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            S_TICK:
            begin
                if (tick_done && out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
        if (cfg_we)
            state_next = S_CLEAR;
    end

    // datapath and memory control
    always_comb
    begin
        cap_next      = cap_reg;
        fc_next       = fc_reg;
        lw_next       = lw_reg;
        pc_next       = pc_reg;
        clr_next      = clr_reg;
        tick_idx_next = tick_idx_reg;
        tick_vld_next = tick_vld_reg;
        op_next       = op_reg;
        hok_next      = hok_reg;
        addr_next     = addr_reg;
        hgen_next     = hgen_reg;
        sidx_next     = sidx_reg;
        ov_next       = ov_reg && !rsp.ready;
        ostat_next    = ostat_reg;
        oidx_next     = oidx_reg;
        ogen_next     = ogen_reg;
        olive_next    = olive_reg;

        free_we = 1'b0; free_waddr = '0; free_wdata = '0;
        free_re = 1'b0; free_raddr = '0;
        gen_we  = 1'b0; gen_waddr  = '0; gen_wdata  = '0;
        gen_re  = 1'b0; gen_raddr  = '0;
        pend_we = 1'b0; pend_waddr = '0; pend_wdata = '0;
        pend_re = 1'b0; pend_raddr = '0;

        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg != cap_reg)
                begin
                    gen_we    = 1'b1;
                    gen_waddr = IDX_W'(clr_reg);
                    clr_next  = clr_reg + CNT_W'(1);
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next       = req.op;
                    hok_next      = req_in_range;
                    addr_next     = req_addr;
                    hgen_next     = GEN_BITS'(32'(req.handle_generation));
                    tick_idx_next = '0;
                    tick_vld_next = 1'b0;
                    if (req.op == OP_ALLOC)
                    begin
                        free_re    = (fc_reg != '0);
                        free_raddr = IDX_W'(pos);
                    end
                    else if (req.op == OP_RELEASE || req.op == OP_VALIDATE)
                    begin
                        gen_re    = 1'b1;
                        gen_raddr = req_addr;
                    end
                end
            end
            S_LOOKUP:
            begin
                case (op_reg)
                    OP_ALLOC:
                    begin
                        if (fc_reg == '0)
                        begin
                            if (out_free)
                            begin
                                ov_next    = 1'b1;
                                ostat_next = ST_FULL;
                                oidx_next  = '0;
                                ogen_next  = '0;
                                olive_next = 1'b0;
                            end
                        end
                        else
                        begin
                            // pop, then fetch the slot's generation
                            sidx_next = pop_idx;
                            gen_re    = 1'b1;
                            gen_raddr = pop_idx;
                            fc_next   = pos;
                            if (pos < lw_reg)
                                lw_next = pos;
                        end
                    end
                    OP_RELEASE:
                    begin
                        if (out_free)
                        begin
                            if (live)
                            begin
                                gen_we    = 1'b1;
                                gen_waddr = addr_reg;
                                gen_wdata = gen_rd_q + GEN_BITS'(1);
                                if (pc_reg != FULL_CNT)
                                begin
                                    pend_we    = 1'b1;
                                    pend_waddr = IDX_W'(pc_reg);
                                    pend_wdata = addr_reg;
                                    pc_next    = pc_reg + CNT_W'(1);
                                end
                            end
                            ov_next    = 1'b1;
                            ostat_next = live ? ST_OK : ST_BAD;
                            oidx_next  = '0;
                            ogen_next  = '0;
                            olive_next = 1'b0;
                        end
                    end
                    OP_VALIDATE:
                    begin
                        if (out_free)
                        begin
                            ov_next    = 1'b1;
                            ostat_next = live ? ST_OK : ST_BAD;
                            oidx_next  = '0;
                            ogen_next  = '0;
                            olive_next = live;
                        end
                    end
                    default:
                    begin
                        ov_next = ov_reg && !rsp.ready;
                    end
                endcase
            end
            S_ALLOC_GEN:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    ostat_next = ST_OK;
                    oidx_next  = SIDX_W'(32'(sidx_reg));
                    ogen_next  = HGEN_W'(32'(gen_rd_q));
                    olive_next = 1'b0;
                end
            end
            S_TICK:
            begin
                // push the entry read last cycle; extra entries drop once the stack is full
                if (tick_vld_reg && fc_reg != FULL_CNT)
                begin
                    free_we    = 1'b1;
                    free_waddr = IDX_W'(fc_reg);
                    free_wdata = pend_rd_q;
                    fc_next    = fc_reg + CNT_W'(1);
                end
                if (tick_idx_reg != pc_reg)
                begin
                    pend_re       = 1'b1;
                    pend_raddr    = IDX_W'(tick_idx_reg);
                    tick_idx_next = tick_idx_reg + CNT_W'(1);
                    tick_vld_next = 1'b1;
                end
                else
                begin
                    tick_vld_next = 1'b0;
                end
                if (tick_done && out_free)
                begin
                    pc_next    = '0;
                    ov_next    = 1'b1;
                    ostat_next = ST_OK;
                    oidx_next  = '0;
                    ogen_next  = '0;
                    olive_next = 1'b0;
                end
            end
            default:
            begin
                clr_next = '0;
            end
        endcase

        // capacity write rebuilds everything
        if (cfg_we)
        begin
            cap_next = cfg_cap;
            fc_next  = cfg_cap;
            lw_next  = cfg_cap;
            pc_next  = '0;
            clr_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            cap_reg      <= RST_CAP;
            fc_reg       <= RST_CAP;
            lw_reg       <= RST_CAP;
            pc_reg       <= '0;
            clr_reg      <= '0;
            tick_idx_reg <= '0;
            tick_vld_reg <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cap_reg      <= cap_next;
            fc_reg       <= fc_next;
            lw_reg       <= lw_next;
            pc_reg       <= pc_next;
            clr_reg      <= clr_next;
            tick_idx_reg <= tick_idx_next;
            tick_vld_reg <= tick_vld_next;
            ov_reg       <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        hok_reg   <= hok_next;
        addr_reg  <= addr_next;
        hgen_reg  <= hgen_next;
        sidx_reg  <= sidx_next;
        ostat_reg <= ostat_next;
        oidx_reg  <= oidx_next;
        ogen_reg  <= ogen_next;
        olive_reg <= olive_next;
    end

    // free stack memory
    always_ff @(posedge clk)
    begin
        if (free_we)
            free_mem[free_waddr] <= free_wdata;
        if (free_re)
            free_rd_q <= free_mem[free_raddr];
    end

    // generation table memory
    always_ff @(posedge clk)
    begin
        if (gen_we)
            gen_mem[gen_waddr] <= gen_wdata;
        if (gen_re)
            gen_rd_q <= gen_mem[gen_raddr];
    end

    // pending list memory
    always_ff @(posedge clk)
    begin
        if (pend_we)
            pend_mem[pend_waddr] <= pend_wdata;
        if (pend_re)
            pend_rd_q <= pend_mem[pend_raddr];
    end

    // watermark never above the free count, else pops would read stale indices
    a_watermark: assert property (@(posedge clk) disable iff (!rst_n)
        lw_reg <= fc_reg)
        else $error("free stack watermark above free count");

    a_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (fc_reg <= FULL_CNT) && (pc_reg <= FULL_CNT) && (cap_reg <= FULL_CNT))
        else $error("count beyond slot count");

    a_gen_write: assert property (@(posedge clk) disable iff (!rst_n)
        gen_we |-> (state_reg == S_CLEAR || state_reg == S_LOOKUP))
        else $error("generation write outside clear or lookup");

    a_free_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(free_we && free_re))
        else $error("free stack read and write in one cycle");

    a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !cfg_we) |=> (state_reg == S_LOOKUP || state_reg == S_TICK))
        else $error("accepted word not processed");

endmodule

`default_nettype wire

FILE: tb/generational_handle_allocator_test.sv
// testbench for the generational handle allocator: directed and random request streams
// checked word by word against a built-in predictor of slots, generations and pending list
// depends on gha_pkg, gha_req_if, gha_rsp_if and generational_handle_allocator
`timescale 1ns / 1ps

module generational_handle_allocator_test;
    import gha_pkg::*;

    // model size, matches the default parameters of the block
    localparam int SLOTS        = DEF_MAX_SLOTS;
    localparam int RESET_CYCLES = 10;
    // watchdog limit, kept far above what a correct run needs
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int POOL_DEPTH   = 32;
    localparam int FLOOD_RELEASES = 1030;
    localparam int PHASE_WORDS  = 24;

    typedef struct packed {
        status_t           status;
        logic [SIDX_W-1:0] slot_index;
        logic [HGEN_W-1:0] slot_generation;
        logic              is_live;
    } rsp_word_t;

    typedef struct {
        logic signed [HIDX_W-1:0] idx;
        logic [HGEN_W-1:0]        gen;
    } handle_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [CAP_W-1:0]  cfg_wdata;

    gha_req_if req_ch ();
    gha_rsp_if rsp_ch ();

    generational_handle_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // predicted allocator state
    logic [SIDX_W-1:0] free_slots [SLOTS];
    int                free_cnt;
    logic [HGEN_W-1:0] gen_tab [SLOTS];
    logic [SIDX_W-1:0] pending_slots [SLOTS];
    int                pending_cnt;
    int                slot_limit;

    // response words still owed by the block, oldest first
    rsp_word_t expected_rsp [$];
    // handles granted so far, live or stale, reused as release/validate targets
    handle_t   handle_pool [$];

    int        err_cnt;
    int        cycle_cnt;
    int        src_idle_pct;
    int        sink_stall_pct;
    int        hold_left;
    rsp_word_t rsp_head;

    // clock and watchdog
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // back to the post-write state: free stack 0..n-1 with n-1 on top
    function automatic void rebuild_slots(input int cap);
        slot_limit = (cap > SLOTS) ? SLOTS : cap;
        for (int i = 0; i < SLOTS; i++)
        begin
            gen_tab[i]       = '0;
            pending_slots[i] = '0;
            free_slots[i]    = (i < slot_limit) ? SIDX_W'(i) : '0;
        end
        free_cnt    = slot_limit;
        pending_cnt = 0;
        handle_pool.delete();
    endfunction

    // live means non-negative, below the capacity and carrying the current generation
    function automatic bit handle_is_live(input logic signed [HIDX_W-1:0] hidx,
                                          input logic [HGEN_W-1:0] hgen);
        if (hidx[HIDX_W-1])
            return 1'b0;
        if (int'(hidx[SIDX_W-1:0]) >= slot_limit)
            return 1'b0;
        return gen_tab[hidx[SIDX_W-1:0]] == hgen;
    endfunction

    function automatic rsp_word_t predict_response(input op_t op,
                                                   input logic signed [HIDX_W-1:0] hidx,
                                                   input logic [HGEN_W-1:0] hgen);
        rsp_word_t         r;
        logic [SIDX_W-1:0] slot;
        r      = '0;
        r.status = ST_OK;
        slot   = hidx[SIDX_W-1:0];
        case (op)
            OP_ALLOC:
            begin
                if (free_cnt == 0)
                    r.status = ST_FULL;
                else
                begin
                    free_cnt--;
                    r.slot_index      = free_slots[free_cnt];
                    r.slot_generation = gen_tab[r.slot_index];
                end
            end
            OP_RELEASE:
            begin
                if (!handle_is_live(hidx, hgen))
                    r.status = ST_BAD;
                else
                begin
                    // generation bumps even when the pending list has no room
                    gen_tab[slot] = gen_tab[slot] + 1'b1;
                    if (pending_cnt < SLOTS)
                    begin
                        pending_slots[pending_cnt] = slot;
                        pending_cnt++;
                    end
                end
            end
            OP_VALIDATE:
            begin
                if (handle_is_live(hidx, hgen))
                    r.is_live = 1'b1;
                else
                    r.status = ST_BAD;
            end
            default:
            begin
                // oldest pending first, overflow of the free stack is dropped
                for (int i = 0; i < pending_cnt; i++)
                begin
                    if (free_cnt < SLOTS)
                    begin
                        free_slots[free_cnt] = pending_slots[i];
                        free_cnt++;
                    end
                end
                pending_cnt = 0;
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // response side: ready pattern and word checker
    // ------------------------------------------------------------------

    // ready changes at the falling edge; hold_left forces a long stall
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // one line per mismatch
    task automatic report_mismatch(input string field, input int want, input int got);
        err_cnt++;
        $display("mismatch: %s expected %0d got %0d at cycle %0d",
                 field, want, got, cycle_cnt);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_rsp.size() == 0)
                report_mismatch("unexpected word", 0, 1);
            else
            begin
                rsp_head = expected_rsp.pop_front();
                if (rsp_ch.status != rsp_head.status)
                    report_mismatch("status", rsp_head.status, rsp_ch.status);
                if (rsp_ch.slot_index != rsp_head.slot_index)
                    report_mismatch("slot_index", rsp_head.slot_index, rsp_ch.slot_index);
                if (rsp_ch.slot_generation != rsp_head.slot_generation)
                    report_mismatch("slot_generation", rsp_head.slot_generation,
                                    rsp_ch.slot_generation);
                if (rsp_ch.is_live != rsp_head.is_live)
                    report_mismatch("is_live", rsp_head.is_live, rsp_ch.is_live);
            end
        end
    end

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // offer one word, wait for the handshake, then predict its response
    task automatic send_request(input op_t op, input logic signed [HIDX_W-1:0] hidx,
                                input logic [HGEN_W-1:0] hgen);
        rsp_word_t r;
        handle_t   h;
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid             <= 1'b1;
        req_ch.op                <= op;
        req_ch.handle_index      <= hidx;
        req_ch.handle_generation <= hgen;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        r = predict_response(op, hidx, hgen);
        expected_rsp = {expected_rsp, r};
        if (op == OP_ALLOC && r.status == ST_OK)
        begin
            h.idx = {1'b0, r.slot_index};
            h.gen = r.slot_generation;
            handle_pool = {handle_pool, h};
            if (handle_pool.size() > POOL_DEPTH)
                void'(handle_pool.pop_front());
        end
    endtask

    // drop valid and wait until every owed word has come back
    task automatic drain_responses();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
    endtask

    // capacity is only written with the block idle; the block then clears itself
    task automatic write_capacity(input int cap);
        drain_responses();
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= CAP_W'(cap);
        @(negedge clk);
        cfg_we    <= 1'b0;
        rebuild_slots(cap);
    endtask

    // mostly small capacities so the free stack runs dry often
    function automatic int pick_capacity();
        case ($urandom_range(0, 7))
            0: return 2;
            1: return 3;
            2: return 5;
            3: return 8;
            4: return 16;
            5: return 64;
            6: return $urandom_range(1, 2047);
            default: return 1024;
        endcase
    endfunction

    // mostly well-formed traffic on granted handles, some noise and bad handles
    task automatic pick_request(output op_t op, output logic signed [HIDX_W-1:0] hidx,
                                output logic [HGEN_W-1:0] hgen);
        int      r;
        int      sel;
        int      v;
        handle_t h;
        r    = $urandom_range(0, 99);
        hidx = '0;
        hgen = '0;
        if (r < 6)
        begin
            // raw noise over every bit of every field
            op   = op_t'($urandom_range(0, 3));
            v    = $urandom_range(0, 2047);
            hidx = v[HIDX_W-1:0];
            hgen = HGEN_W'($urandom_range(0, 65535));
            return;
        end
        if (r < 40)
            op = OP_ALLOC;
        else if (r < 65)
            op = OP_RELEASE;
        else if (r < 90)
            op = OP_VALIDATE;
        else
            op = OP_TICK;
        if (op == OP_ALLOC || op == OP_TICK)
            return;
        sel = $urandom_range(0, 9);
        if (sel <= 4 && handle_pool.size() != 0)
        begin
            // granted handle, possibly stale by now
            h    = handle_pool[$urandom_range(0, handle_pool.size() - 1)];
            hidx = h.idx;
            hgen = h.gen;
        end
        else if (sel == 9 && handle_pool.size() != 0)
        begin
            // generation off by one either way
            h    = handle_pool[$urandom_range(0, handle_pool.size() - 1)];
            hidx = h.idx;
            hgen = $urandom_range(0, 1) ? h.gen + 1'b1 : h.gen - 1'b1;
        end
        else if (sel == 8 || slot_limit == 0)
        begin
            // null or beyond the capacity
            if (slot_limit < SLOTS && $urandom_range(0, 1))
                v = $urandom_range(slot_limit, SLOTS - 1);
            else
                v = -int'($urandom_range(1, 1024));
            hidx = v[HIDX_W-1:0];
            hgen = HGEN_W'($urandom_range(0, 65535));
        end
        else
        begin
            // any slot in range, with the current or a random generation
            v    = $urandom_range(0, slot_limit - 1);
            hidx = v[HIDX_W-1:0];
            hgen = (sel == 7) ? HGEN_W'($urandom_range(0, 65535))
                              : gen_tab[v[SIDX_W-1:0]];
        end
    endtask

    task automatic send_random_words(input int count);
        op_t                      op;
        logic signed [HIDX_W-1:0] hidx;
        logic [HGEN_W-1:0]        hgen;
        for (int n = 0; n < count; n++)
        begin
            pick_request(op, hidx, hgen);
            send_request(op, hidx, hgen);
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset capacity: top slot first, stale handles, null handles, tick order
    task automatic test_reset_defaults();
        src_idle_pct   = 37;
        sink_stall_pct = 37;
        send_request(OP_ALLOC, 11'sd0, 16'd0);
        send_request(OP_VALIDATE, 11'sd1023, 16'd0);
        send_request(OP_RELEASE, 11'sd1023, 16'd0);
        // old copy of the handle is now stale
        send_request(OP_VALIDATE, 11'sd1023, 16'd0);
        send_request(OP_RELEASE, 11'sd1023, 16'd0);
        send_request(OP_VALIDATE, -11'sd1, 16'd0);
        send_request(OP_VALIDATE, -11'sd1024, 16'hffff);
        // slot never granted but carrying its generation counts as live
        send_request(OP_RELEASE, 11'sd5, 16'd0);
        send_request(OP_VALIDATE, 11'sd0, 16'hffff);
        send_request(OP_TICK, 11'sd0, 16'd0);
        send_request(OP_ALLOC, 11'sd0, 16'd0);
        send_request(OP_ALLOC, 11'sd0, 16'd0);
        send_request(OP_ALLOC, 11'sd0, 16'd0);
    endtask

    // zero capacity, one slot, and a value above the slot count
    task automatic test_capacity_extremes();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        write_capacity(0);
        send_request(OP_ALLOC, 11'sd0, 16'd0);
        send_request(OP_VALIDATE, 11'sd0, 16'd0);
        send_request(OP_RELEASE, 11'sd0, 16'd0);
        send_request(OP_TICK, 11'sd0, 16'd0);
        write_capacity(1);
        send_request(OP_ALLOC, 11'sd0, 16'd0);
        send_request(OP_ALLOC, 11'sd0, 16'd0);
        send_request(OP_VALIDATE, 11'sd0, 16'd0);
        send_request(OP_VALIDATE, 11'sd1, 16'd0);
        send_request(OP_RELEASE, 11'sd0, 16'd0);
        send_request(OP_TICK, 11'sd0, 16'd0);
        send_request(OP_ALLOC, 11'sd0, 16'd0);
        write_capacity(2047);
        send_request(OP_ALLOC, 11'sd0, 16'd0);
        send_request(OP_VALIDATE, 11'sd1023, 16'd0);
        send_request(OP_RELEASE, 11'sd1023, 16'hffff);
    endtask

    // one slot released over and over in a single frame: the pending list overflows,
    // and the tick then overfills the free stack with copies of the slot
    task automatic test_pending_overflow();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        write_capacity(1);
        for (int n = 0; n < FLOOD_RELEASES; n++)
        begin
            if (n == FLOOD_RELEASES - 3)
                send_request(OP_TICK, 11'sd0, 16'd0);
            else
                send_request(OP_RELEASE, 11'sd0, gen_tab[0]);
        end
        send_request(OP_VALIDATE, 11'sd0, gen_tab[0]);
        send_request(OP_VALIDATE, 11'sd0, gen_tab[0] - 1'b1);
        send_request(OP_ALLOC, 11'sd0, 16'd0);
        send_request(OP_TICK, 11'sd0, 16'd0);
        send_request(OP_ALLOC, 11'sd0, 16'd0);
    endtask

    // random traffic over several idle patterns, fresh capacity per phase
    task automatic test_random_traffic();
        int src_pat  [4] = '{0, 46, 0, 37};
        int sink_pat [4] = '{0, 0, 46, 37};
        for (int p = 0; p < 8; p++)
        begin
            write_capacity(pick_capacity());
            src_idle_pct   = src_pat[p % 4];
            sink_stall_pct = sink_pat[p % 4];
            send_random_words(PHASE_WORDS);
        end
    endtask

    // long receiver stall while requests keep coming, then a full sender pause
    task automatic test_backpressure();
        write_capacity(8);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_left      = 400;
        send_random_words(40);
        drain_responses();
        sink_stall_pct = 46;
        send_random_words(20);
    endtask

    initial
    begin
        rst_n                    = 1'b0;
        cfg_we                   = 1'b0;
        cfg_wdata                = '0;
        req_ch.valid             = 1'b0;
        req_ch.op                = OP_ALLOC;
        req_ch.handle_index      = '0;
        req_ch.handle_generation = '0;
        err_cnt                  = 0;
        cycle_cnt                = 0;
        src_idle_pct             = 0;
        sink_stall_pct           = 0;
        hold_left                = 0;
        rebuild_slots(CAP_RESET);
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_capacity_extremes();
        test_pending_overflow();
        test_random_traffic();
        test_backpressure();

        // everything owed back, then a short tail to catch stray words
        drain_responses();
        repeat (20) @(posedge clk);
        if (err_cnt == 0 && expected_rsp.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
